// ===== hdl/cst_pkg.sv =====
// Shared types and constants of the client session tracker.
`timescale 1ns / 1ps

package cst_pkg;

   localparam int SLOTS_DEFAULT = 8;
   localparam int QUEUE_DEPTH   = 2;
   localparam int QPTR_W        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] AVG_LIMIT = 8'd255;

   // event kinds
   localparam logic OP_CONNECT    = 1'b0;
   localparam logic OP_DISCONNECT = 1'b1;

   // result status codes
   localparam logic [1:0] ST_DONE    = 2'd0;
   localparam logic [1:0] ST_FULL    = 2'd1;
   localparam logic [1:0] ST_MISSING = 2'd2;

   typedef struct packed {
      logic        operation;
      logic [47:0] mac;
      logic [31:0] now_sec;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [2:0]  slot;
      logic [31:0] closed_time;
      logic [31:0] session_count;
      logic [7:0]  average_time;
      logic [31:0] since_start;
   } rsp_type;

   // item as classified by the front end
   typedef struct packed {
      logic        operation;
      logic [47:0] mac;
      logic [31:0] now_sec;
      logic [31:0] since_start;
   } q_entry_type;

   typedef struct packed {
      logic        start;
      logic [31:0] dividend;
      logic [31:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic       done;
      logic [7:0] quotient;
   } div_rsp_type;

endpackage

// ===== hdl/cst_front.sv =====
// Front end: session start register, transaction intake and classification.
`timescale 1ns / 1ps

module cst_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [31:0]          csr_wr_data,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  cst_pkg::req_type     req_data,
   output logic                 push,
   output cst_pkg::q_entry_type push_data,
   input  logic                 q_full
);

   logic [31:0] session_start_ff;
   logic [31:0] session_start_in;

   assign session_start_in = csr_wr_en ? csr_wr_data : session_start_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         session_start_ff <= '0;
      end else begin
         session_start_ff <= session_start_in;
      end
   end

   assign req_stall = q_full;
   assign push      = req_valid & ~q_full;

   always_comb begin
      push_data.operation   = req_data.operation;
      push_data.mac         = req_data.mac;
      push_data.now_sec     = req_data.now_sec;
      push_data.since_start = req_data.now_sec - session_start_ff;
   end

endmodule

// ===== hdl/cst_queue.sv =====
// Short FIFO between the front end and the slot engine.
`timescale 1ns / 1ps

module cst_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  cst_pkg::q_entry_type push_data,
   output logic                 full,
   output logic                 pop_valid,
   output cst_pkg::q_entry_type pop_data,
   input  logic                 pop
);

   localparam int                    DEPTH = cst_pkg::QUEUE_DEPTH;
   localparam logic [cst_pkg::QPTR_W-1:0] LAST  = cst_pkg::QPTR_W'(DEPTH - 1);

   cst_pkg::q_entry_type entry_ff [DEPTH];

   logic [cst_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [cst_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [cst_pkg::QCNT_W-1:0] count_ff, count_in;
   logic                       do_push, do_pop;

   assign full      = (count_ff == cst_pkg::QCNT_W'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_data  = entry_ff[rd_ptr_ff];
   assign do_push   = push & ~full;
   assign do_pop    = pop & pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== hdl/cst_divider.sv =====
// Radix-2 restoring divider for the average, result saturated to 8 bits.
`timescale 1ns / 1ps

module cst_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  cst_pkg::div_req_type div_req,
   output cst_pkg::div_rsp_type div_rsp
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [4:0]  step_ff, step_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] quo_ff, quo_in;
   logic [31:0] dvs_ff, dvs_in;
   logic [7:0]  q8_ff, q8_in;
   logic [32:0] trial;
   logic [32:0] diff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      q8_in   = q8_ff;
      trial   = {rem_ff, quo_ff[31]};
      diff    = trial - {1'b0, dvs_ff};
      if (div_req.start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = '0;
         quo_in  = div_req.dividend;
         dvs_in  = div_req.divisor;
      end else if (busy_ff) begin
         if (!diff[32]) begin
            rem_in = diff[31:0];
            quo_in = {quo_ff[30:0], 1'b1};
         end else begin
            rem_in = trial[31:0];
            quo_in = {quo_ff[30:0], 1'b0};
         end
         step_in = step_ff + 1'b1;
         if (step_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            q8_in   = (|quo_in[31:8]) ? cst_pkg::AVG_LIMIT : quo_in[7:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dvs_ff  <= dvs_in;
      q8_ff   <= q8_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = q8_ff;

endmodule

// ===== hdl/cst_engine.sv =====
// Back end: slot table, MAC search, totals and the result register.
`timescale 1ns / 1ps

module cst_engine #(
   parameter int SLOTS = cst_pkg::SLOTS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 pop_valid,
   input  cst_pkg::q_entry_type pop_data,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output cst_pkg::rsp_type     rsp_data,
   output cst_pkg::div_req_type div_req,
   input  cst_pkg::div_rsp_type div_rsp
);

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_SCAN_RD  = 3'd1;
   localparam logic [2:0] S_SCAN_CMP = 3'd2;
   localparam logic [2:0] S_DIV_GO   = 3'd3;
   localparam logic [2:0] S_DIV_WAIT = 3'd4;

   typedef struct packed {
      logic [47:0] mac;
      logic [31:0] start;
   } slot_entry_type;

   slot_entry_type mem [SLOTS];
   slot_entry_type rd_data_ff;
   logic           mem_we;
   logic [IDX_W-1:0] mem_waddr;
   slot_entry_type   mem_wdata;

   logic [2:0]       state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [SLOTS-1:0] valid_ff, valid_in;
   logic [31:0]      total_ff, total_in;
   logic [31:0]      count_ff, count_in;
   logic [7:0]       avg_ff, avg_in;
   logic             rsp_valid_ff, rsp_valid_in;
   cst_pkg::rsp_type rsp_ff, rsp_in;
   cst_pkg::q_entry_type work_ff, work_in;

   logic             any_free;
   logic [IDX_W-1:0] free_idx;
   logic [31:0]      closed;

   // lowest free slot
   always_comb begin
      any_free = 1'b0;
      free_idx = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            any_free = 1'b1;
            free_idx = IDX_W'(i);
         end
      end
   end

   assign closed = work_ff.now_sec - rd_data_ff.start;

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      valid_in     = valid_ff;
      total_in     = total_ff;
      count_in     = count_ff;
      avg_in       = avg_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_in       = rsp_ff;
      work_in      = work_ff;
      pop          = 1'b0;
      mem_we       = 1'b0;
      mem_waddr    = free_idx;
      mem_wdata.mac   = pop_data.mac;
      mem_wdata.start = pop_data.now_sec;
      div_req.start    = 1'b0;
      div_req.dividend = total_ff;
      div_req.divisor  = count_ff;

      case (state_ff)
         S_IDLE: begin
            if (pop_valid && !rsp_valid_ff) begin
               pop     = 1'b1;
               work_in = pop_data;
               rsp_in.session_count = count_ff;
               rsp_in.average_time  = avg_ff;
               rsp_in.since_start   = pop_data.since_start;
               rsp_in.closed_time   = '0;
               rsp_in.slot          = '0;
               if (pop_data.operation == cst_pkg::OP_CONNECT) begin
                  rsp_valid_in = 1'b1;
                  if (any_free) begin
                     mem_we             = 1'b1;
                     valid_in[free_idx] = 1'b1;
                     rsp_in.status      = cst_pkg::ST_DONE;
                     rsp_in.slot        = 3'(free_idx);
                  end else begin
                     rsp_in.status = cst_pkg::ST_FULL;
                  end
               end else begin
                  rsp_in.status = cst_pkg::ST_MISSING;
                  idx_in        = '0;
                  state_in      = S_SCAN_RD;
               end
            end
         end
         S_SCAN_RD: begin
            // read of mem[idx] lands in rd_data_ff
            state_in = S_SCAN_CMP;
         end
         S_SCAN_CMP: begin
            if (valid_ff[idx_ff] && rd_data_ff.mac == work_ff.mac) begin
               valid_in[idx_ff]     = 1'b0;
               total_in             = total_ff + closed;
               count_in             = count_ff + 1'b1;
               rsp_in.status        = cst_pkg::ST_DONE;
               rsp_in.slot          = 3'(idx_ff);
               rsp_in.closed_time   = closed;
               rsp_in.session_count = count_in;
               if (count_in == '0) begin
                  // count wrapped: no average
                  avg_in              = '0;
                  rsp_in.average_time = '0;
                  rsp_valid_in        = 1'b1;
                  state_in            = S_IDLE;
               end else begin
                  state_in = S_DIV_GO;
               end
            end else if (idx_ff == LAST_IDX) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_SCAN_RD;
            end
         end
         S_DIV_GO: begin
            div_req.start = 1'b1;
            state_in      = S_DIV_WAIT;
         end
         S_DIV_WAIT: begin
            if (div_rsp.done) begin
               avg_in              = div_rsp.quotient;
               rsp_in.average_time = div_rsp.quotient;
               rsp_valid_in        = 1'b1;
               state_in            = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         idx_ff       <= '0;
         valid_ff     <= '0;
         total_ff     <= '0;
         count_ff     <= '0;
         avg_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         valid_ff     <= valid_in;
         total_ff     <= total_in;
         count_ff     <= count_in;
         avg_ff       <= avg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff  <= rsp_in;
      work_ff <= work_in;
   end

   // slot memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[idx_ff];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== hdl/client_session_tracker.sv =====
// Top level of the client session tracker.
`timescale 1ns / 1ps

// Channel   Direction  Handshake                Payload
// req_      in         req_valid / req_stall    cst_pkg::req_type (operation, mac, now_sec)
// rsp_      out        rsp_valid / rsp_stall    cst_pkg::rsp_type (status .. since_start)
// csr_      in         csr_wr_en                csr_wr_data = session start, seconds
//
// Connect: entry registered in the queue, engine pop, then the result register loads.
// Disconnect: pop, then each slot scanned through the registered slot-memory read in a
//   read state and a compare state; a hit adds the bit-serial average divider, worst
//   case a hit in the last slot.
// Reset is synchronous; valid bits, totals and queue clear together, no sweep.
// req_stall rises only when the two-entry queue is full; rsp_stall holds the
//   result register, and the engine waits without dropping its transaction.

module client_session_tracker #(
   parameter int SLOTS = cst_pkg::SLOTS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  cst_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output cst_pkg::rsp_type rsp_data,
   input  logic             csr_wr_en,
   input  logic [31:0]      csr_wr_data
);

   // front end -> queue
   logic                 push;
   cst_pkg::q_entry_type push_data;
   logic                 q_full;

   // queue -> engine
   logic                 pop_valid;
   cst_pkg::q_entry_type pop_data;
   logic                 pop;

   // engine <-> divider
   cst_pkg::div_req_type div_req;
   cst_pkg::div_rsp_type div_rsp;

   // Front end holds the session start and computes the elapsed session time
   // at intake, so configuration never races the back end.
   cst_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .push        (push),
      .push_data   (push_data),
      .q_full      (q_full)
   );

   cst_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (q_full),
      .pop_valid (pop_valid),
      .pop_data  (pop_data),
      .pop       (pop)
   );

   // Engine: lowest-free-slot claim on connect, sequential MAC scan on
   // disconnect, running totals and the result register.
   cst_engine #(
      .SLOTS (SLOTS)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_data  (pop_data),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .div_req   (div_req),
      .div_rsp   (div_rsp)
   );

   // Average = total / count, one quotient bit per cycle.
   cst_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

endmodule
